// ----- design/htb_pkg.sv -----
// htb_pkg: shared types and constants for the huffman tree builder
// command and status codes, request/response structs, queue and node entries
// no dependencies
package htb_pkg;

	localparam int ID_W    = 9;
	localparam int WGT_W   = 40;
	localparam int FREQ_W  = 32;

	localparam logic [ID_W-1:0]  LEAF_BASE  = 9'd256;
	localparam logic [WGT_W-1:0] WEIGHT_MAX = {WGT_W{1'b1}};

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_BUILD = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_NOTMADE = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [7:0]        symbol;
		logic              present;
		logic [FREQ_W-1:0] frequency;
		logic [ID_W-1:0]   node_index;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [ID_W-1:0]  root_index;
		logic [ID_W-1:0]  left_child;
		logic [ID_W-1:0]  right_child;
		logic [WGT_W-1:0] node_weight;
		logic             is_leaf;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [WGT_W-1:0] w;
	} qent_t;

	typedef struct packed {
		logic [ID_W-1:0]  left;
		logic [ID_W-1:0]  right;
		logic [WGT_W-1:0] w;
	} node_t;

endpackage

// ----- design/htb_ram.sv -----
// htb_ram: synchronous ram, one write port and one read port, registered read
// no dependencies
module htb_ram #(
	parameter int W  = 8,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	localparam int DEPTH = 1 << AW;

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- design/huffman_tree_builder.sv -----
// huffman_tree_builder: top level, builds a huffman tree from symbol frequencies
// load writes the leaf ram; read checks the index, then returns node data; build scans leaves
// into a weight-sorted queue, then merges the two lightest entries until one root remains
// one transaction at a time, busy high while working; results cannot be stalled
// arst_n clears present flags, counts, root and sets the tree empty
// depends on htb_pkg and htb_ram
module huffman_tree_builder #(
	parameter int SYMBOLS   = 256,
	parameter int FREQ_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  htb_pkg::req_t req,
	output logic          done,
	output htb_pkg::rsp_t rsp
);

	localparam int QW    = $clog2(SYMBOLS);
	localparam int DEPTH = 1 << QW;
	localparam int LW    = (FREQ_BITS < htb_pkg::FREQ_W) ? FREQ_BITS : htb_pkg::FREQ_W;
	localparam int NW    = $bits(htb_pkg::node_t);
	localparam int EW    = $bits(htb_pkg::qent_t);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SCAN    = 4'd1;
	localparam logic [3:0] S_LEAFW   = 4'd2;
	localparam logic [3:0] S_INS     = 4'd3;
	localparam logic [3:0] S_INS_CMP = 4'd4;
	localparam logic [3:0] S_MERGE   = 4'd5;
	localparam logic [3:0] S_POPA    = 4'd6;
	localparam logic [3:0] S_POPB    = 4'd7;
	localparam logic [3:0] S_ROOT    = 4'd8;
	localparam logic [3:0] S_RD      = 4'd9;

	logic [3:0]                    state_q;
	logic [DEPTH-1:0]              present_q;
	logic [QW:0]                   scan_q;
	logic [QW-1:0]                 head_q;
	logic [QW:0]                   cnt_q;
	logic [QW:0]                   pos_q;
	logic [QW-1:0]                 ic_q;
	logic                          phase_q;
	logic [htb_pkg::ID_W-1:0]      root_q;
	logic                          empty_q;
	logic [htb_pkg::ID_W-1:0]      ins_id_q;
	logic [htb_pkg::WGT_W-1:0]     ins_w_q;
	logic [htb_pkg::ID_W-1:0]      a_id_q;
	logic [htb_pkg::WGT_W-1:0]     a_w_q;
	logic [1:0]                    rd_stat_q;
	logic                          rd_leaf_q;
	logic                          done_q;
	htb_pkg::rsp_t                 rsp_q;

	logic                          accept;
	logic                          sym_ok;
	logic                          resp_set;
	htb_pkg::rsp_t                 rsp_d;
	logic                          lw_we;
	logic [QW-1:0]                 lw_raddr;
	logic [LW-1:0]                 lw_rdata;
	logic                          q_we;
	logic [QW-1:0]                 q_waddr;
	htb_pkg::qent_t                q_wdata;
	logic [QW-1:0]                 q_raddr;
	logic [EW-1:0]                 q_rraw;
	htb_pkg::qent_t                rq;
	logic                          nd_we;
	htb_pkg::node_t                nd_wdata;
	logic [NW-1:0]                 nd_rraw;
	htb_pkg::node_t                nd;
	logic [QW-1:0]                 slot_a;
	logic [QW-1:0]                 slot_m1;
	logic [htb_pkg::WGT_W:0]       sum_w;
	logic [htb_pkg::WGT_W-1:0]     sum_sat;
	htb_pkg::qent_t                ins_ent;
	logic [htb_pkg::ID_W-1:0]      idx;
	logic                          leaf_ok;
	logic                          int_ok;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign rsp     = rsp_q;
	assign rq      = htb_pkg::qent_t'(q_rraw);
	assign nd      = htb_pkg::node_t'(nd_rraw);
	assign slot_a  = head_q + pos_q[QW-1:0];
	assign slot_m1 = slot_a - 1'b1;
	assign sum_w   = {1'b0, a_w_q} + {1'b0, rq.w};
	assign sum_sat = sum_w[htb_pkg::WGT_W] ? htb_pkg::WEIGHT_MAX : sum_w[htb_pkg::WGT_W-1:0];
	assign ins_ent = '{id: ins_id_q, w: ins_w_q};
	assign idx     = req.node_index;
	assign sym_ok  = {1'b0, req.symbol} < 9'(SYMBOLS);
	assign leaf_ok = (idx < htb_pkg::ID_W'(SYMBOLS)) && present_q[idx[QW-1:0]];
	assign int_ok  = idx[8] && (idx[7:0] < 8'(ic_q));

	assign lw_we    = accept && (req.cmd == htb_pkg::CMD_LOAD) && sym_ok;
	assign lw_raddr = (state_q == S_IDLE) ? idx[QW-1:0] : scan_q[QW-1:0];
	assign nd_we    = (state_q == S_POPB);
	assign nd_wdata = '{left: a_id_q, right: rq.id, w: sum_sat};

	assign resp_set = (accept && (req.cmd != htb_pkg::CMD_BUILD) && (req.cmd != htb_pkg::CMD_READ))
		|| (state_q == S_RD) || (state_q == S_ROOT)
		|| ((state_q == S_MERGE) && (cnt_q == '0));

	always_comb begin
		rsp_d = '0;
		rsp_d.root_index = root_q;
		case (state_q)
			S_MERGE: begin
				rsp_d.status     = htb_pkg::ST_EMPTY;
				rsp_d.root_index = '0;
			end
			S_ROOT: begin
				rsp_d.root_index = rq.id;
			end
			S_RD: begin
				rsp_d.status = rd_stat_q;
				if (rd_stat_q == htb_pkg::ST_OK) begin
					if (rd_leaf_q) begin
						rsp_d.node_weight = htb_pkg::WGT_W'(lw_rdata);
						rsp_d.is_leaf     = 1'b1;
					end else begin
						rsp_d.left_child  = nd.left;
						rsp_d.right_child = nd.right;
						rsp_d.node_weight = nd.w;
					end
				end
			end
			default: begin
				rsp_d.status = htb_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		q_we    = 1'b0;
		q_waddr = slot_a;
		q_wdata = ins_ent;
		q_raddr = slot_m1;
		case (state_q)
			S_INS: begin
				q_we = (pos_q == '0);
			end
			S_INS_CMP: begin
				q_we = 1'b1;
				if (rq.w > ins_w_q) begin
					q_wdata = rq;
				end
			end
			S_MERGE: begin
				q_raddr = head_q;
			end
			S_POPA: begin
				q_raddr = head_q + 1'b1;
			end
			default: begin
				q_raddr = slot_m1;
			end
		endcase
	end

	htb_ram #(.W(LW), .AW(QW)) u_leaf_ram (
		.clk   (clk),
		.we    (lw_we),
		.waddr (req.symbol[QW-1:0]),
		.wdata (req.frequency[LW-1:0]),
		.raddr (lw_raddr),
		.rdata (lw_rdata)
	);

	htb_ram #(.W(EW), .AW(QW)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (EW'(q_wdata)),
		.raddr (q_raddr),
		.rdata (q_rraw)
	);

	htb_ram #(.W(NW), .AW(QW)) u_node_ram (
		.clk   (clk),
		.we    (nd_we),
		.waddr (ic_q),
		.wdata (NW'(nd_wdata)),
		.raddr (idx[QW-1:0]),
		.rdata (nd_rraw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			present_q <= '0;
			scan_q    <= '0;
			head_q    <= '0;
			cnt_q     <= '0;
			pos_q     <= '0;
			ic_q      <= '0;
			phase_q   <= 1'b0;
			root_q    <= '0;
			empty_q   <= 1'b1;
			rd_stat_q <= htb_pkg::ST_OK;
			rd_leaf_q <= 1'b0;
			done_q    <= 1'b0;
			rsp_q     <= '0;
		end else begin
			done_q <= resp_set;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (req.cmd)
							htb_pkg::CMD_LOAD: begin
								if (sym_ok) begin
									present_q[req.symbol[QW-1:0]] <= req.present;
								end
							end
							htb_pkg::CMD_BUILD: begin
								scan_q  <= '0;
								head_q  <= '0;
								cnt_q   <= '0;
								ic_q    <= '0;
								phase_q <= 1'b0;
								state_q <= S_SCAN;
							end
							htb_pkg::CMD_READ: begin
								rd_leaf_q <= !idx[8];
								if (empty_q) begin
									rd_stat_q <= htb_pkg::ST_EMPTY;
								end else if (idx[8] ? int_ok : leaf_ok) begin
									rd_stat_q <= htb_pkg::ST_OK;
								end else begin
									rd_stat_q <= htb_pkg::ST_NOTMADE;
								end
								state_q <= S_RD;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_q == (QW+1)'(SYMBOLS)) begin
						phase_q <= 1'b1;
						state_q <= S_MERGE;
					end else if (present_q[scan_q[QW-1:0]]) begin
						state_q <= S_LEAFW;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_LEAFW: begin
					ins_id_q <= htb_pkg::ID_W'(scan_q);
					ins_w_q  <= htb_pkg::WGT_W'(lw_rdata);
					pos_q    <= cnt_q;
					scan_q   <= scan_q + 1'b1;
					state_q  <= S_INS;
				end
				S_INS: begin
					if (pos_q == '0) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= phase_q ? S_MERGE : S_SCAN;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (rq.w > ins_w_q) begin
						pos_q   <= pos_q - 1'b1;
						state_q <= S_INS;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= phase_q ? S_MERGE : S_SCAN;
					end
				end
				S_MERGE: begin
					if (cnt_q >= (QW+1)'(2)) begin
						state_q <= S_POPA;
					end else if (cnt_q == (QW+1)'(1)) begin
						state_q <= S_ROOT;
					end else begin
						empty_q <= 1'b1;
						root_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_POPA: begin
					a_id_q  <= rq.id;
					a_w_q   <= rq.w;
					state_q <= S_POPB;
				end
				S_POPB: begin
					ins_id_q <= htb_pkg::LEAF_BASE + htb_pkg::ID_W'(ic_q);
					ins_w_q  <= sum_sat;
					head_q   <= head_q + QW'(2);
					cnt_q    <= cnt_q - (QW+1)'(2);
					pos_q    <= cnt_q - (QW+1)'(2);
					ic_q     <= ic_q + 1'b1;
					state_q  <= S_INS;
				end
				S_ROOT: begin
					root_q  <= rq.id;
					empty_q <= 1'b0;
					cnt_q   <= '0;
					state_q <= S_IDLE;
				end
				S_RD: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (resp_set) begin
				rsp_q <= rsp_d;
			end
		end
	end

endmodule
